// ===== design/expected_sarsa_q_table_agent_assert.svh =====
// ----------------------------------------------------------------------------
// Expected-SARSA agent assertion macros
// Shared concurrent assertion forms used by the agent's modules.
// ----------------------------------------------------------------------------
`ifndef EXPECTED_SARSA_Q_TABLE_AGENT_ASSERT_SVH
`define EXPECTED_SARSA_Q_TABLE_AGENT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESQA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ESQA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/esqa_pkg.sv =====
// ----------------------------------------------------------------------------
// Expected-SARSA agent package
// Types and fixed constants shared by the agent's modules.
// ----------------------------------------------------------------------------
package esqa_pkg;

  localparam int QW = 32;   // Q16.16 value width
  localparam int RW = 17;   // Q1.16 rate width
  localparam int MW = 56;   // multiply accumulator width
  localparam int DW = 40;   // dividend width
  localparam int GW = MW - 16;

  localparam logic [RW-1:0] ONE_Q16 = 17'd65536;
  localparam int HALF_Q16 = 32768;
  localparam int EXPLORE_SCALE = 1000;

  localparam logic [1:0] KIND_CHOOSE = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_DISCOUNT   = 1'b1;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_SCAN,
    ST_READ,
    ST_CUR,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_MUL3,
    ST_MUL4,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// ===== design/esqa_chan_if.sv =====
// ----------------------------------------------------------------------------
// Expected-SARSA agent channels
// Valid/ready request and result channels of the agent.
// ----------------------------------------------------------------------------
interface esqa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         state_index;
  logic [1:0]         action_index;
  logic signed [31:0] reward;
  logic [5:0]         next_state;
  logic [16:0]        explore_prob;
  logic [9:0]         rand_explore;
  logic [1:0]         rand_action;
  logic [3:0]         tie_bits;

  modport source (output valid, kind, state_index, action_index, reward, next_state,
                  explore_prob, rand_explore, rand_action, tie_bits, input ready);
  modport sink (input valid, kind, state_index, action_index, reward, next_state,
                explore_prob, rand_explore, rand_action, tie_bits, output ready);
endinterface

interface esqa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         chosen_action;
  logic               explored;
  logic signed [31:0] q_value;

  modport source (output valid, chosen_action, explored, q_value, input ready);
  modport sink (input valid, chosen_action, explored, q_value, output ready);
endinterface

// ===== design/expected_sarsa_q_table_agent.sv =====
// ----------------------------------------------------------------------------
// Expected-SARSA Q-table agent
// Tabular epsilon-greedy action choice, expected-SARSA update and Q read.
// ----------------------------------------------------------------------------
// One request is in work at a time; in_ch.ready is high only while idle, and a
// finished result waits in the output register while the next request enters.
// After reset a clearing pass zeroes all 2^(clog2(STATE_COUNT) +
// clog2(ACTION_COUNT)) Q memory entries (256 at defaults); no request is taken during it.
// After acceptance and wrapping, an exploring choice or an unused kind goes
// straight to the output register, a read fetches its entry, a greedy choice
// scans the ACTION_COUNT entries of its row, and an update scans the next row,
// fetches the current entry, runs two bit-serial multiplies, a divide by
// ACTION_COUNT (a byte at a time by reciprocal multiplication) and two more
// multiplies in the shared arithmetic unit, then writes back. Indices at or above
// the table size are wrapped by subtraction; a stalled output holds the block in ST_DONE.
`include "expected_sarsa_q_table_agent_assert.svh"

module expected_sarsa_q_table_agent #(
  parameter int STATE_COUNT  = 64,
  parameter int ACTION_COUNT = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  esqa_in_if.sink                 in_ch,
  esqa_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [esqa_pkg::RW-1:0] cfg_data
);
  import esqa_pkg::*;

  localparam int SW     = $clog2(STATE_COUNT);
  localparam int AW     = $clog2(ACTION_COUNT);
  localparam int MAW    = SW + AW;
  localparam int MDEPTH = 2 ** MAW;
  localparam int CNW    = $clog2(ACTION_COUNT + 1);
  localparam int SUMW   = QW + AW;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;
  logic   mem_we, out_load, wrap_pend, explore;
  alu_req_t alu_req;
  alu_sts_t alu_sts;
  logic signed [MW-1:0] alu_a, alu_init, alu_res;
  logic [RW-1:0]        alu_b;

  logic [MAW-1:0] clr_r, waddr, raddr;
  logic signed [QW-1:0] mem [MDEPTH];
  logic signed [QW-1:0] rdata_r, wdata;

  logic [RW-1:0] learn_r, disc_r, alpha, gamma;
  logic [1:0]  kind_r, act_r, ract_r;
  logic [5:0]  row_r, nrow_r, scan_row;
  logic [RW-1:0] eps_r;
  logic [9:0]  rexp_r;
  logic [3:0]  ties_r;
  logic signed [QW-1:0] reward_r, cur_r, bval_r, bval_nxt;
  logic [CNW-1:0] cnt_r, idx;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic          neg_r;
  logic signed [DW:0] e_r;
  logic signed [GW-1:0] g_r, d_r, x_w;
  logic [DW-1:0] mag;
  logic signed [MW-1:0] nbest, t_w;
  logic signed [GW:0]   nq_w;
  logic signed [QW-1:0] nq_sat;
  logic [1:0]  res_act_r, out_act_r;
  logic        res_exp_r, out_exp_r, out_valid_r;
  logic signed [QW-1:0] res_q_r, out_q_r;
  logic [26:0] eps_k;

  assign alpha = (learn_r > ONE_Q16) ? ONE_Q16 : learn_r;
  assign gamma = (disc_r > ONE_Q16) ? ONE_Q16 : disc_r;
  assign eps_k = 27'(eps_r) * 27'(EXPLORE_SCALE);
  assign explore = 27'({rexp_r, 16'h0000}) < eps_k;

  assign wrap_pend = ({7'd0, row_r} >= 13'(STATE_COUNT)) || ({7'd0, nrow_r} >= 13'(STATE_COUNT))
                  || ({3'd0, act_r} >= 5'(ACTION_COUNT)) || ({3'd0, ract_r} >= 5'(ACTION_COUNT));

  // scan datapath
  assign idx = cnt_r - CNW'(1);
  always_comb begin
    sum_nxt  = sum_r + SUMW'(rdata_r);
    bval_nxt = bval_r;
    best_nxt = best_r;
    if (idx == '0) begin
      sum_nxt  = SUMW'(rdata_r);
      bval_nxt = rdata_r;
      best_nxt = '0;
    end else if (rdata_r > bval_r) begin
      bval_nxt = rdata_r;
      best_nxt = AW'(idx);
    end else if (rdata_r == bval_r && (32'(idx) < 32'd4) && ties_r[idx[1:0]]) begin
      best_nxt = AW'(idx);
    end
  end

  assign nbest = MW'(bval_r) * $signed(MW'(ACTION_COUNT));
  assign x_w   = alu_res[MW-1:16];
  assign mag   = x_w[GW-1] ? DW'(-x_w + GW'(ACTION_COUNT - 1)) : DW'(x_w);
  assign t_w   = MW'(reward_r) + MW'(g_r) - MW'(cur_r);
  assign nq_w  = (GW+1)'(cur_r) + (GW+1)'(d_r);
  assign nq_sat = (nq_w > (GW+1)'(32'sh7fffffff)) ? 32'sh7fffffff :
                  (nq_w < -(GW+1)'(33'sh80000000)) ? 32'sh80000000 : QW'(nq_w);

  always_comb begin
    case (state_r)
      ST_MUL1: begin
        alu_a = MW'(sum_r); alu_b = eps_r; alu_init = MW'(HALF_Q16 * ACTION_COUNT);
      end
      ST_MUL2: begin
        alu_a = nbest; alu_b = ONE_Q16 - eps_r; alu_init = alu_res;
      end
      ST_DIV: begin
        alu_a = MW'(mag); alu_b = '0; alu_init = '0;
      end
      ST_MUL3: begin
        alu_a = MW'(e_r); alu_b = gamma; alu_init = MW'(HALF_Q16);
      end
      default: begin
        alu_a = t_w; alu_b = alpha; alu_init = MW'(HALF_Q16);
      end
    endcase
  end

  esqa_alu #(.ACTION_COUNT(ACTION_COUNT)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .opa  (alu_a),
    .opb  (alu_b),
    .init (alu_init),
    .sts  (alu_sts),
    .res  (alu_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = go_r;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    in_ch.ready   = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = (state_r == ST_DIV) ? ALU_DIV : ALU_MUL;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (!wrap_pend) begin
          case (kind_r)
            KIND_CHOOSE: state_nxt = explore ? ST_DONE : ST_SCAN;
            KIND_UPDATE: state_nxt = ST_SCAN;
            KIND_READ:   state_nxt = ST_READ;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNW'(ACTION_COUNT)) state_nxt = (kind_r == KIND_UPDATE) ? ST_CUR : ST_DONE;
      end
      ST_READ, ST_CUR: begin
        go_nxt = !go_r;
        if (go_r) state_nxt = (state_r == ST_READ) ? ST_DONE : ST_MUL1;
      end
      ST_MUL1, ST_MUL2, ST_DIV, ST_MUL3, ST_MUL4: begin
        if (!go_r) begin
          alu_req.start = 1'b1;
          go_nxt        = 1'b1;
        end else if (alu_sts.done) begin
          go_nxt = 1'b0;
          case (state_r)
            ST_MUL1: state_nxt = ST_MUL2;
            ST_MUL2: state_nxt = ST_DIV;
            ST_DIV:  state_nxt = ST_MUL3;
            ST_MUL3: state_nxt = ST_MUL4;
            default: state_nxt = ST_WRITE;
          endcase
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Q memory
  assign scan_row = (kind_r == KIND_UPDATE) ? nrow_r : row_r;
  assign raddr = (state_r == ST_SCAN) ? {SW'(scan_row), AW'(cnt_r)} : {SW'(row_r), AW'(act_r)};
  assign waddr = (state_r == ST_CLEAR) ? clr_r : {SW'(row_r), AW'(act_r)};
  assign wdata = (state_r == ST_CLEAR) ? '0 : nq_sat;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_r <= clr_r + MAW'(1);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_r <= 17'd6554;
      disc_r  <= 17'd58982;
    end else if (cfg_we) begin
      if (cfg_index == REG_LEARN_RATE) learn_r <= cfg_data;
      if (cfg_index == REG_DISCOUNT)   disc_r  <= cfg_data;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kind_r    <= in_ch.kind;
        row_r     <= in_ch.state_index;
        act_r     <= in_ch.action_index;
        reward_r  <= in_ch.reward;
        nrow_r    <= in_ch.next_state;
        eps_r     <= (in_ch.explore_prob > ONE_Q16) ? ONE_Q16 : in_ch.explore_prob;
        rexp_r    <= in_ch.rand_explore;
        ract_r    <= in_ch.rand_action;
        ties_r    <= in_ch.tie_bits;
        res_act_r <= '0;
        res_exp_r <= 1'b0;
        res_q_r   <= '0;
      end
      ST_WRAP: begin
        cnt_r <= '0;
        if ({7'd0, row_r} >= 13'(STATE_COUNT))  row_r  <= row_r - 6'(STATE_COUNT);
        if ({7'd0, nrow_r} >= 13'(STATE_COUNT)) nrow_r <= nrow_r - 6'(STATE_COUNT);
        if ({3'd0, act_r} >= 5'(ACTION_COUNT))  act_r  <= act_r - 2'(ACTION_COUNT);
        if ({3'd0, ract_r} >= 5'(ACTION_COUNT)) ract_r <= ract_r - 2'(ACTION_COUNT);
        if (!wrap_pend && kind_r == KIND_CHOOSE && explore) begin
          res_act_r <= ract_r;
          res_exp_r <= 1'b1;
        end
      end
      ST_SCAN: begin
        cnt_r <= cnt_r + CNW'(1);
        if (cnt_r != '0) begin
          sum_r  <= sum_nxt;
          bval_r <= bval_nxt;
          best_r <= best_nxt;
        end
        if (cnt_r == CNW'(ACTION_COUNT) && kind_r == KIND_CHOOSE) res_act_r <= 2'(best_nxt);
      end
      ST_READ: if (go_r) res_q_r <= rdata_r;
      ST_CUR:  if (go_r) cur_r <= rdata_r;
      ST_DIV: begin
        if (!go_r) neg_r <= x_w[GW-1];
        else if (alu_sts.done)
          e_r <= neg_r ? -$signed({1'b0, alu_res[DW-1:0]}) : $signed({1'b0, alu_res[DW-1:0]});
      end
      ST_MUL3: if (go_r && alu_sts.done) g_r <= alu_res[MW-1:16];
      ST_MUL4: if (go_r && alu_sts.done) d_r <= alu_res[MW-1:16];
      ST_WRITE: res_q_r <= nq_sat;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_act_r <= res_act_r;
      out_exp_r <= res_exp_r;
      out_q_r   <= res_q_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_action = out_act_r;
  assign out_ch.explored      = out_exp_r;
  assign out_ch.q_value       = out_q_r;

  `ESQA_ASSERT_NEXT(a_one_req, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ESQA_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_r || out_ch.ready)
  `ESQA_ASSERT_NOW(a_alu_free, alu_req.start, !alu_sts.busy)

endmodule

// ===== design/esqa_alu.sv =====
// ----------------------------------------------------------------------------
// Expected-SARSA shared arithmetic unit
// Bit-serial multiply-accumulate and byte-wise reciprocal divide by the action
// count.
// ----------------------------------------------------------------------------
`include "expected_sarsa_q_table_agent_assert.svh"

module esqa_alu #(
  parameter int ACTION_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esqa_pkg::alu_req_t             req,
  input  logic signed [esqa_pkg::MW-1:0] opa,
  input  logic [esqa_pkg::RW-1:0]        opb,
  input  logic signed [esqa_pkg::MW-1:0] init,
  output esqa_pkg::alu_sts_t             sts,
  output logic signed [esqa_pkg::MW-1:0] res
);
  import esqa_pkg::*;

  localparam int CW    = $clog2(ACTION_COUNT);
  localparam int DG    = 8;
  localparam int VW    = CW + DG;
  localparam int PW    = 16 + DG;
  localparam int RECIP = (65536 + ACTION_COUNT - 1) / ACTION_COUNT;
  localparam int DSTEP = DW / DG;

  logic              busy_r, done_r;
  alu_op_t           op_r;
  logic [5:0]        cnt_r;
  logic signed [MW-1:0] acc_r, a_r;
  logic [RW-1:0]     b_r;
  logic [CW-1:0]     rem_r;
  logic [DW-1:0]     quo_r;
  logic [VW-1:0]     dvd;
  logic [PW-1:0]     prod;
  logic [DG-1:0]     qdig;
  logic [CW-1:0]     rdig;
  logic              last;

  // one quotient byte per step: partial remainder and next dividend byte
  assign dvd   = {rem_r, quo_r[DW-1 -: DG]};
  assign prod  = PW'(dvd) * PW'(RECIP);
  assign qdig  = prod[PW-1:16];
  assign rdig  = CW'(dvd - VW'(qdig) * VW'(ACTION_COUNT));
  assign last  = (op_r == ALU_MUL) ? (cnt_r == 6'(RW-1)) : (cnt_r == 6'(DSTEP-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ALU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= init;
      a_r   <= opa;
      b_r   <= opb;
      quo_r <= opa[DW-1:0];
      rem_r <= '0;
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r <= a_r <<< 1;
        b_r <= b_r >> 1;
      end else begin
        rem_r <= rdig;
        quo_r <= {quo_r[DW-DG-1:0], qdig};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res = (op_r == ALU_MUL) ? acc_r : $signed(MW'(quo_r));

  `ESQA_ASSERT_NEXT(a_start_busy, req.start, busy_r)
  `ESQA_ASSERT_NOW(a_no_restart, req.start, !busy_r)
  `ESQA_ASSERT_NEXT(a_done_idle, busy_r && last && !req.start, done_r && !busy_r)

endmodule

// ===== tb/sv/expected_sarsa_q_table_agent_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Expected-SARSA Q-table agent testbench
// Drives choose, update and read requests through the valid/ready channel,
// predicts every result from a local copy of the Q table and the rate
// registers, and compares each result field by field. Runs several phases
// with different rate settings and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module expected_sarsa_q_table_agent_tb;
  import esqa_pkg::*;

  localparam int  ROWS       = 64;
  localparam int  ACTS       = 4;
  localparam int  DRAIN      = 300;
  localparam int  CYCLE_CAP  = 2000000;
  localparam int  PHASE_REQS = 230;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         st;
    logic [1:0]         act;
    logic signed [31:0] reward;
    logic [5:0]         nst;
    logic [16:0]        eps;
    logic [9:0]         rexp;
    logic [1:0]         ract;
    logic [3:0]         ties;
  } agent_req_t;

  typedef struct packed {
    logic [1:0]         chosen;
    logic               explored;
    logic signed [31:0] qv;
  } agent_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [RW-1:0] cfg_data;

  esqa_in_if  in_ch();
  esqa_out_if out_ch();

  expected_sarsa_q_table_agent u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  agent_req_t  pending_reqs[$];
  agent_res_t  expected_res[$];
  agent_req_t  driven_req;
  logic signed [31:0] q_model[ROWS*ACTS];
  logic [16:0] alpha_reg;
  logic [16:0] gamma_reg;
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_rate(logic [16:0] v);
    return (v > 17'd65536) ? 65536 : longint'(v);
  endfunction

  function automatic longint round_quot(longint n, longint d);
    longint m;
    longint q;
    m = n + d / 2;
    q = m / d;
    if ((m % d) != 0 && m < 0) q--;
    return q;
  endfunction

  function automatic int greedy_action(int row, logic [3:0] ties);
    int best;
    logic signed [31:0] best_val;
    best = 0;
    best_val = q_model[row*ACTS];
    for (int a = 0; a < ACTS; a++) begin
      if (q_model[row*ACTS+a] > best_val) begin
        best_val = q_model[row*ACTS+a];
        best = a;
      end else if (q_model[row*ACTS+a] == best_val && ties[a]) begin
        best = a;
      end
    end
    return best;
  endfunction

  function automatic agent_res_t agent_predict(agent_req_t r);
    agent_res_t o;
    longint eps, sum, num, e, g, t, d, cur, nv;
    int best;
    o = '0;
    eps = clamp_rate(r.eps);
    if (r.kind == KIND_CHOOSE) begin
      if (longint'(r.rexp) * 65536 < eps * EXPLORE_SCALE) begin
        o.chosen = r.ract;
        o.explored = 1'b1;
      end else begin
        o.chosen = 2'(greedy_action(r.st, r.ties));
      end
    end else if (r.kind == KIND_UPDATE) begin
      best = greedy_action(r.nst, r.ties);
      sum = 0;
      for (int a = 0; a < ACTS; a++) sum += longint'(q_model[r.nst*ACTS+a]);
      num = eps * sum + longint'(ACTS) * (65536 - eps) * longint'(q_model[r.nst*ACTS+best]);
      e = round_quot(num, 65536 * ACTS);
      g = round_quot(clamp_rate(gamma_reg) * e, 65536);
      cur = longint'(q_model[r.st*ACTS+r.act]);
      t = longint'(r.reward) + g - cur;
      d = round_quot(clamp_rate(alpha_reg) * t, 65536);
      nv = cur + d;
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      o.qv = 32'(nv);
      q_model[r.st*ACTS+r.act] = o.qv;
    end else if (r.kind == KIND_READ) begin
      o.qv = q_model[r.st*ACTS+r.act];
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.state_index <= '0;
      in_ch.action_index <= '0;
      in_ch.reward <= '0;
      in_ch.next_state <= '0;
      in_ch.explore_prob <= '0;
      in_ch.rand_explore <= '0;
      in_ch.rand_action <= '0;
      in_ch.tie_bits <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_res.push_back(agent_predict(driven_req));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        driven_req = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= driven_req.kind;
        in_ch.state_index <= driven_req.st;
        in_ch.action_index <= driven_req.act;
        in_ch.reward <= driven_req.reward;
        in_ch.next_state <= driven_req.nst;
        in_ch.explore_prob <= driven_req.eps;
        in_ch.rand_explore <= driven_req.rexp;
        in_ch.rand_action <= driven_req.ract;
        in_ch.tie_bits <= driven_req.ties;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    agent_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result act=%0d exp=%0d q=%0d", $realtime,
                   out_ch.chosen_action, out_ch.explored, out_ch.q_value);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (out_ch.chosen_action !== want.chosen) begin
            $display("%0t: chosen_action expected %0d actual %0d", $realtime,
                     want.chosen, out_ch.chosen_action);
            errors++;
          end
          if (out_ch.explored !== want.explored) begin
            $display("%0t: explored expected %0d actual %0d", $realtime,
                     want.explored, out_ch.explored);
            errors++;
          end
          if (out_ch.q_value !== want.qv) begin
            $display("%0t: q_value expected %0d actual %0d", $realtime,
                     want.qv, out_ch.q_value);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic agent_req_t mk_req(int kind, int st, int act, int reward, int nst,
                                        int eps, int rexp, int ract, int ties);
    agent_req_t r;
    r.kind = 2'(kind);
    r.st = 6'(st);
    r.act = 2'(act);
    r.reward = reward;
    r.nst = 6'(nst);
    r.eps = 17'(eps);
    r.rexp = 10'(rexp);
    r.ract = 2'(ract);
    r.ties = 4'(ties);
    return r;
  endfunction

  function automatic agent_req_t random_req();
    agent_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.kind = (pick < 35) ? KIND_UPDATE : (pick < 70) ? KIND_CHOOSE :
             (pick < 94) ? KIND_READ : 2'd3;
    r.st = ($urandom_range(9) < 8) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    r.nst = ($urandom_range(9) < 8) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    r.act = 2'($urandom_range(3));
    r.ract = 2'($urandom_range(3));
    pick = $urandom_range(99);
    r.reward = (pick < 60) ? $signed($urandom_range(262144)) - 131072 :
               (pick < 80) ? $urandom :
               (pick < 90) ? 32'h7fffffff : 32'h80000000;
    pick = $urandom_range(99);
    r.eps = (pick < 40) ? 17'($urandom_range(65536)) : (pick < 60) ? 17'd0 :
            (pick < 80) ? 17'd65536 : 17'($urandom_range(131071));
    r.rexp = 10'($urandom_range(1023));
    r.ties = 4'($urandom_range(15));
    return r;
  endfunction

  task automatic drain_all();
    wait (pending_reqs.size() == 0 && !in_ch.valid && expected_res.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [RW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_LEARN_RATE) alpha_reg = val;
    else gamma_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int send_pcts[4];
    int stall_pcts[4];
    logic [16:0] alphas[4];
    logic [16:0] gammas[4];
    send_pcts = '{0, 55, 0, 35};
    stall_pcts = '{0, 0, 55, 35};
    alphas = '{17'd65536, 17'd0, 17'd131071, 17'd40000};
    gammas = '{17'd65536, 17'd0, 17'd1, 17'd131071};
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    alpha_reg = 17'd6554;
    gamma_reg = 17'd58982;
    for (int i = 0; i < ROWS*ACTS; i++) q_model[i] = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    pending_reqs.push_back(mk_req(KIND_CHOOSE, 0, 0, 0, 0, 0, 0, 2, 0));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 0, 0, 0, 0, 0, 0, 2, 4'b1000));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 63, 0, 0, 0, 0, 1023, 1, 4'b0110));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 1, 0, 0, 0, 65536, 999, 3, 0));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 1, 0, 0, 0, 131071, 1023, 3, 4'b1111));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 1, 0, 0, 0, 1, 0, 1, 0));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 1, 0, 0, 0, 1, 1, 1, 0));
    pending_reqs.push_back(mk_req(KIND_UPDATE, 63, 3, 32'h7fffffff, 63, 0, 0, 0, 4'b1111));
    pending_reqs.push_back(mk_req(KIND_UPDATE, 0, 0, 32'h80000000, 63, 65536, 0, 0, 0));
    pending_reqs.push_back(mk_req(KIND_UPDATE, 2, 1, 65536, 63, 131071, 0, 0, 4'b0101));
    pending_reqs.push_back(mk_req(KIND_UPDATE, 2, 2, 65536, 2, 32768, 0, 0, 4'b0010));
    pending_reqs.push_back(mk_req(KIND_UPDATE, 2, 3, -1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 2, 0, 0, 0, 0, 500, 0, 4'b0100));
    pending_reqs.push_back(mk_req(KIND_CHOOSE, 2, 0, 0, 0, 0, 500, 0, 4'b0000));
    pending_reqs.push_back(mk_req(KIND_READ, 63, 3, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(KIND_READ, 2, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(KIND_READ, 2, 2, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(3, 63, 3, 32'h7fffffff, 63, 131071, 1023, 3, 15));
    pending_reqs.push_back(mk_req(KIND_READ, 63, 3, 0, 0, 0, 0, 0, 0));
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_LEARN_RATE, alphas[ph]);
      write_reg(REG_DISCOUNT, gammas[ph]);
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = stall_pcts[ph];
      for (int i = 0; i < PHASE_REQS; i++) pending_reqs.push_back(random_req());
      drain_all();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
